// File: rtl/spq_pkg.sv
// Shared types, codes and default sizes for the sorted priority queue.
package spq_pkg;

	localparam int DEF_QUEUE_DEPTH = 16;
	localparam int DEF_DATA_BITS   = 32;
	localparam int DEF_PRIO_BITS   = 16;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	localparam logic [1:0] STAT_INSERTED  = 2'd0;
	localparam logic [1:0] STAT_REMOVED   = 2'd1;
	localparam logic [1:0] STAT_UNDERFLOW = 2'd2;
	localparam logic [1:0] STAT_OVERFLOW  = 2'd3;

	// Command from the controller to the datapath.
	typedef struct packed {
		logic       load;
		logic [1:0] op;
	} spq_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;
		logic empty;
	} spq_sts_t;

endpackage

// File: rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: controller plus cell-row datapath.
//
// Usage: an input transaction carries req_type (insert or remove), data_value
// and priority_value. Inserts are placed behind every stored entry whose
// priority is lower or equal, so the smallest priority leaves first and equal
// priorities leave in arrival order. Every input transaction yields exactly one
// output transaction with status, out_data, out_priority and occupancy.
// Removing from an empty queue reports underflow; inserting into a full queue
// drops the entry and reports overflow.
//
// The result of a transaction accepted at one edge is
// valid after that edge. Throughput is one transaction per cycle, set by the
// row of cells, which compare against the new priority in parallel and shift
// in a single step. The output register lets a new transaction in during the
// same cycle the waiting result is taken; while the receiver stalls, the result
// is held and in_ready stays low.
//
// Reset (arst_n low) empties the queue at once; no clearing pass is needed.
module sorted_priority_queue #(
	parameter int QUEUE_DEPTH = spq_pkg::DEF_QUEUE_DEPTH,
	parameter int DATA_BITS   = spq_pkg::DEF_DATA_BITS,
	parameter int PRIO_BITS   = spq_pkg::DEF_PRIO_BITS,
	parameter int OCC_BITS    = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        req_type,
	input  logic signed [DATA_BITS-1:0] data_value,
	input  logic signed [PRIO_BITS-1:0] priority_value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic        [1:0]           status,
	output logic signed [DATA_BITS-1:0] out_data,
	output logic signed [PRIO_BITS-1:0] out_priority,
	output logic        [OCC_BITS-1:0]  occupancy
);
	import spq_pkg::*;

	// Command and status between the controller and the datapath.
	spq_cmd_t cmd;
	spq_sts_t sts;

	// The controller decides the operation from the request and the fill state.
	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the sorted entries and the output register.
	spq_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.DATA_BITS   (DATA_BITS),
		.PRIO_BITS   (PRIO_BITS),
		.OCC_BITS    (OCC_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.data_value     (data_value),
		.priority_value (priority_value),
		.status         (status),
		.out_data       (out_data),
		.out_priority   (out_priority),
		.occupancy      (occupancy)
	);

endmodule

// File: rtl/spq_ctrl.sv
// Controller: accepts transactions, picks the operation and tracks the result register.
module spq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              req_type,
	output logic              out_valid,
	input  logic              out_ready,
	input  spq_pkg::spq_sts_t sts,
	output spq_pkg::spq_cmd_t cmd
);
	import spq_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_RESULT
	} state_t;

	state_t state_q;
	logic   accept;

	// A waiting result may be replaced in the same cycle it is taken.
	assign in_ready  = (state_q == ST_IDLE) || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = (state_q == ST_RESULT);

	always_comb begin
		cmd.load = accept;
		unique case (req_type)
			REQ_INSERT: cmd.op = sts.full  ? STAT_OVERFLOW  : STAT_INSERTED;
			REQ_REMOVE: cmd.op = sts.empty ? STAT_UNDERFLOW : STAT_REMOVED;
			default:    cmd.op = STAT_UNDERFLOW;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (out_ready && !accept) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/spq_datapath.sv
// Datapath: a row of sorted cells with parallel compare, plus the result register.
module spq_datapath #(
	parameter int QUEUE_DEPTH = spq_pkg::DEF_QUEUE_DEPTH,
	parameter int DATA_BITS   = spq_pkg::DEF_DATA_BITS,
	parameter int PRIO_BITS   = spq_pkg::DEF_PRIO_BITS,
	parameter int OCC_BITS    = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  spq_pkg::spq_cmd_t           cmd,
	output spq_pkg::spq_sts_t           sts,
	input  logic signed [DATA_BITS-1:0] data_value,
	input  logic signed [PRIO_BITS-1:0] priority_value,
	output logic        [1:0]           status,
	output logic signed [DATA_BITS-1:0] out_data,
	output logic signed [PRIO_BITS-1:0] out_priority,
	output logic        [OCC_BITS-1:0]  occupancy
);
	import spq_pkg::*;

	logic signed [DATA_BITS-1:0] slot_data_q [QUEUE_DEPTH];
	logic signed [PRIO_BITS-1:0] slot_prio_q [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0]      slot_valid_q;
	logic [OCC_BITS-1:0]         count_q;
	logic [OCC_BITS-1:0]         count_next;

	logic [QUEUE_DEPTH-1:0]      le;
	logic [QUEUE_DEPTH-1:0]      le_prev;
	logic signed [DATA_BITS-1:0] prev_data [QUEUE_DEPTH];
	logic signed [PRIO_BITS-1:0] prev_prio [QUEUE_DEPTH];

	logic [1:0]                  status_q;
	logic signed [DATA_BITS-1:0] out_data_q;
	logic signed [PRIO_BITS-1:0] out_prio_q;
	logic [OCC_BITS-1:0]         occupancy_q;

	// Valid cells form a run from cell 0, so the head and tail bits tell empty and full.
	assign sts.full  = slot_valid_q[QUEUE_DEPTH-1];
	assign sts.empty = !slot_valid_q[0];

	// Each cell compares its own priority; the new entry lands at the first cell that loses.
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			le[i] = slot_valid_q[i] && (slot_prio_q[i] <= priority_value);
		end
		le_prev      = {le[QUEUE_DEPTH-2:0], 1'b1};
		prev_data[0] = data_value;
		prev_prio[0] = priority_value;
		for (int i = 1; i < QUEUE_DEPTH; i++) begin
			prev_data[i] = slot_data_q[i-1];
			prev_prio[i] = slot_prio_q[i-1];
		end
	end

	always_comb begin
		unique case (cmd.op)
			STAT_INSERTED:  count_next = count_q + OCC_BITS'(1);
			STAT_REMOVED:   count_next = count_q - OCC_BITS'(1);
			STAT_UNDERFLOW,
			STAT_OVERFLOW:  count_next = count_q;
			default:        count_next = count_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			count_q      <= '0;
		end else if (cmd.load) begin
			count_q <= count_next;
			unique case (cmd.op)
				STAT_INSERTED: slot_valid_q <= {slot_valid_q[QUEUE_DEPTH-2:0], 1'b1};
				STAT_REMOVED:  slot_valid_q <= {1'b0, slot_valid_q[QUEUE_DEPTH-1:1]};
				STAT_UNDERFLOW,
				STAT_OVERFLOW: slot_valid_q <= slot_valid_q;
				default:       slot_valid_q <= slot_valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && cmd.op == STAT_INSERTED) begin
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				if (!le[i]) begin
					slot_data_q[i] <= le_prev[i] ? data_value : prev_data[i];
					slot_prio_q[i] <= le_prev[i] ? priority_value : prev_prio[i];
				end
			end
		end else if (cmd.load && cmd.op == STAT_REMOVED) begin
			for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
				slot_data_q[i] <= slot_data_q[i+1];
				slot_prio_q[i] <= slot_prio_q[i+1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			status_q    <= cmd.op;
			occupancy_q <= count_next;
			if (cmd.op == STAT_REMOVED) begin
				out_data_q <= slot_data_q[0];
				out_prio_q <= slot_prio_q[0];
			end else begin
				out_data_q <= '0;
				out_prio_q <= '0;
			end
		end
	end

	assign status       = status_q;
	assign out_data     = out_data_q;
	assign out_priority = out_prio_q;
	assign occupancy    = occupancy_q;

endmodule

// File: rtl/spq_checker.sv
// Port-level checks for the sorted priority queue, bound to the top level.
module spq_checker #(
	parameter int QUEUE_DEPTH = spq_pkg::DEF_QUEUE_DEPTH,
	parameter int DATA_BITS   = spq_pkg::DEF_DATA_BITS,
	parameter int PRIO_BITS   = spq_pkg::DEF_PRIO_BITS,
	parameter int OCC_BITS    = $clog2(QUEUE_DEPTH + 1)
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        req_type,
	input logic signed [DATA_BITS-1:0] data_value,
	input logic signed [PRIO_BITS-1:0] priority_value,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic        [1:0]           status,
	input logic signed [DATA_BITS-1:0] out_data,
	input logic signed [PRIO_BITS-1:0] out_priority,
	input logic        [OCC_BITS-1:0]  occupancy
);
	import spq_pkg::*;

	logic unused_in;
	assign unused_in = ^{req_type, data_value, priority_value};

	// A stalled result holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(occupancy)
		&& $stable(out_data) && $stable(out_priority))
		else $error("stalled result changed");

	// Every accepted transaction shows a result in the next cycle.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("result missing after accepted transaction");

	// Overflow only when the queue is full.
	a_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_OVERFLOW |-> occupancy == OCC_BITS'(QUEUE_DEPTH))
		else $error("overflow reported while not full");

	// Underflow only when empty, with zero payload.
	a_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_UNDERFLOW |-> occupancy == '0 && out_data == '0
		&& out_priority == '0)
		else $error("bad underflow result");

	// An insert leaves at least one entry behind and returns zero payload.
	a_insert: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_INSERTED |-> occupancy != '0 && out_data == '0
		&& out_priority == '0)
		else $error("bad insert result");

endmodule

bind sorted_priority_queue spq_checker #(
	.QUEUE_DEPTH (QUEUE_DEPTH),
	.DATA_BITS   (DATA_BITS),
	.PRIO_BITS   (PRIO_BITS),
	.OCC_BITS    (OCC_BITS)
) u_spq_checker (.*);

// File: bench/sorted_priority_queue_tb.sv
// Self-checking testbench for the sorted priority queue with a predictor, random traffic and stalls.
`timescale 1ns / 100ps

module sorted_priority_queue_tb;

	import spq_pkg::*;

	localparam int DEPTH     = DEF_QUEUE_DEPTH;
	localparam int DATA_W    = DEF_DATA_BITS;
	localparam int PRIO_W    = DEF_PRIO_BITS;
	localparam int OCC_W     = $clog2(DEPTH + 1);
	localparam int RANDOM_ITEMS = 950;

	// One result transaction as the block should present it.
	typedef struct {
		logic        [1:0]        status;
		logic signed [DATA_W-1:0] data;
		logic signed [PRIO_W-1:0] prio;
		logic        [OCC_W-1:0]  occ;
	} queue_result_t;

	// Receiver behavior: always ready, mostly ready or seldom ready.
	typedef enum {READY_ALWAYS, READY_MOSTLY, READY_SELDOM} ready_mode_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic                     req_type;
	logic signed [DATA_W-1:0] data_value;
	logic signed [PRIO_W-1:0] priority_value;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic        [1:0]        status;
	logic signed [DATA_W-1:0] out_data;
	logic signed [PRIO_W-1:0] out_priority;
	logic        [OCC_W-1:0]  occupancy;

	// Private copy of the queue contents, kept sorted with slot 0 at the front.
	logic signed [DATA_W-1:0] shadow_data [DEPTH];
	logic signed [PRIO_W-1:0] shadow_prio [DEPTH];
	int                       shadow_count = 0;

	// Results predicted for accepted requests, oldest first.
	queue_result_t awaited_results[$];

	int          error_count = 0;
	int          burst_left  = 0;
	ready_mode_t ready_mode  = READY_ALWAYS;
	int          ready_hold  = 0;

	sorted_priority_queue u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.req_type       (req_type),
		.data_value     (data_value),
		.priority_value (priority_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.out_data       (out_data),
		.out_priority   (out_priority),
		.occupancy      (occupancy)
	);

	always #10 clk = ~clk;

	// Applies one request to the shadow queue and returns the result the block must give.
	// An insert lands behind every entry whose priority is lower or equal, so ties stay
	// in arrival order. The comparison is signed because both operands are signed.
	function automatic queue_result_t apply_request(input logic rt,
			input logic signed [DATA_W-1:0] d, input logic signed [PRIO_W-1:0] p);
		queue_result_t r;
		int            pos;
		int            i;
		r.status = STAT_INSERTED;
		r.data   = '0;
		r.prio   = '0;
		if (rt == REQ_INSERT) begin
			if (shadow_count == DEPTH) begin
				r.status = STAT_OVERFLOW;
			end else begin
				pos = 0;
				while (pos < shadow_count && shadow_prio[pos] <= p)
					pos++;
				for (i = shadow_count; i > pos; i--) begin
					shadow_data[i] = shadow_data[i-1];
					shadow_prio[i] = shadow_prio[i-1];
				end
				shadow_data[pos] = d;
				shadow_prio[pos] = p;
				shadow_count++;
			end
		end else begin
			if (shadow_count == 0) begin
				r.status = STAT_UNDERFLOW;
			end else begin
				r.status = STAT_REMOVED;
				r.data   = shadow_data[0];
				r.prio   = shadow_prio[0];
				for (i = 0; i + 1 < shadow_count; i++) begin
					shadow_data[i] = shadow_data[i+1];
					shadow_prio[i] = shadow_prio[i+1];
				end
				shadow_count--;
			end
		end
		r.occ = shadow_count[OCC_W-1:0];
		return r;
	endfunction

	// Priorities drawn from the full range, a narrow band around zero so that ties are
	// common, or the signed extremes and their neighbors.
	function automatic logic [PRIO_W-1:0] random_priority(input bit tie_heavy);
		int pick;
		pick = $urandom_range(0, 99);
		if (tie_heavy && pick < 70)
			return PRIO_W'($signed($urandom_range(0, 6)) - 3);
		if (pick < 15) begin
			case ($urandom_range(0, 3))
				0: return {1'b1, {(PRIO_W-1){1'b0}}};
				1: return {1'b0, {(PRIO_W-1){1'b1}}};
				2: return {1'b1, {(PRIO_W-2){1'b0}}, 1'b1};
				default: return {1'b0, {(PRIO_W-2){1'b1}}, 1'b0};
			endcase
		end
		if (pick < 40)
			return PRIO_W'($signed($urandom_range(0, 8)) - 4);
		return PRIO_W'($urandom);
	endfunction

	// Sends one request transaction. The task is always entered at a rising edge and
	// returns at the edge where the transaction was accepted, with in_valid still high,
	// so the next call can present its item at once and keep a burst going. Between
	// bursts, in_valid is sometimes dropped for a random gap.
	task automatic send_request(input logic rt, input logic [DATA_W-1:0] d,
			input logic [PRIO_W-1:0] p);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid       <= 1'b1;
		req_type       <= rt;
		data_value     <= d;
		priority_value <= p;
		// Values read right after the edge are the ones the block sampled at that edge.
		do
			@(posedge clk);
		while (!in_ready);
		awaited_results.push_back(apply_request(rt, d, p));
	endtask

	// Holds the sender off until every predicted result has been taken. It always waits
	// for an edge first, so in_valid never gets two assignments in one time step.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (awaited_results.size() != 0);
		burst_left = 0;
	endtask

	// Removing from a queue that has never held anything must report underflow.
	task automatic test_underflow_after_reset();
		send_request(REQ_REMOVE, 32'hA5A5_5A5A, 16'h8001);
	endtask

	// Data and priority extremes: the most negative priority must come out first and the
	// most positive last, with the data words carried through untouched.
	task automatic test_field_extremes();
		send_request(REQ_INSERT, 32'h7FFF_FFFF, 16'h7FFF);
		send_request(REQ_INSERT, 32'h8000_0000, 16'h8000);
		send_request(REQ_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
		send_request(REQ_INSERT, 32'h0000_0000, 16'h0000);
		repeat (4) send_request(REQ_REMOVE, 32'hFFFF_FFFF, 16'h7FFF);
	endtask

	// Fills the queue with falling priorities in equal pairs, so inserts land at the
	// front or just behind a tie; one more insert then overflows.
	task automatic test_fill_and_overflow();
		int k;
		for (k = 0; k < DEPTH; k++)
			send_request(REQ_INSERT, 32'h1000_0000 + k, 16'(8 - k / 2));
		send_request(REQ_INSERT, 32'hDEAD_BEEF, 16'h8000);
		wait_for_results();
	endtask

	// Random traffic in phases: filling phases drive the queue into overflow, draining
	// phases into underflow, and mixed phases hover in between. Some phases use a narrow
	// priority band so that equal priorities pile up. Fields of removes stay random,
	// since the block must ignore them.
	task automatic test_random_traffic(input int total);
		int remaining;
		int phase_len;
		int insert_pct;
		bit tie_heavy;
		logic rt;
		remaining = total;
		while (remaining > 0) begin
			phase_len = $urandom_range(10, 80);
			if (phase_len > remaining)
				phase_len = remaining;
			remaining -= phase_len;
			case ($urandom_range(0, 3))
				0: insert_pct = 85;
				1: insert_pct = 15;
				2: insert_pct = 50;
				default: insert_pct = 60;
			endcase
			tie_heavy = $urandom_range(0, 2) == 0;
			repeat (phase_len) begin
				rt = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_REMOVE;
				send_request(rt, $urandom, random_priority(tie_heavy));
			end
			if ($urandom_range(0, 5) == 0)
				wait_for_results();
		end
	endtask

	// Receiver stalls follow a pattern of their own: long stretches of steady readiness,
	// stretches of occasional stalls and stretches where the receiver is mostly stalled.
	always @(posedge clk) begin
		if (ready_hold == 0) begin
			ready_mode = ready_mode_t'($urandom_range(0, 2));
			ready_hold = $urandom_range(20, 200);
		end
		ready_hold--;
		case (ready_mode)
			READY_ALWAYS: out_ready <= 1'b1;
			READY_MOSTLY: out_ready <= $urandom_range(0, 9) < 7;
			default:      out_ready <= $urandom_range(0, 9) < 2;
		endcase
	end

	// Every result transaction is compared with the oldest prediction, field by field.
	always @(posedge clk) begin
		queue_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				$error("result transaction with no request awaiting it");
				error_count++;
			end else begin
				want = awaited_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, status);
					error_count++;
				end
				if (out_data !== want.data) begin
					$error("out_data: expected %0d, actual %0d", want.data, out_data);
					error_count++;
				end
				if (out_priority !== want.prio) begin
					$error("out_priority: expected %0d, actual %0d", want.prio, out_priority);
					error_count++;
				end
				if (occupancy !== want.occ) begin
					$error("occupancy: expected %0d, actual %0d", want.occ, occupancy);
					error_count++;
				end
			end
		end
	end

	// Stimulus. Inputs start at known values, reset is held low from the start and released
	// on a rising edge, and the tests then run back to back.
	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		req_type       = REQ_INSERT;
		data_value     = '0;
		priority_value = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_underflow_after_reset();
		test_field_extremes();
		test_fill_and_overflow();
		test_random_traffic(RANDOM_ITEMS);

		// Let every result arrive, then keep watching the outputs so that any
		// stray result shows before the verdict.
		wait_for_results();
		repeat (5) @(posedge clk);
		if (error_count == 0)
			$display("sorted_priority_queue_tb: done, clean");
		else
			$display("sorted_priority_queue_tb: done, errors");
		$finish;
	end

	// Watchdog, far beyond the slowest correct run of this stimulus.
	initial begin
		#5_000_000;
		$display("sorted_priority_queue_tb: done, errors");
		$finish;
	end

endmodule

// File: files.f
rtl/spq_pkg.sv
rtl/spq_ctrl.sv
rtl/spq_datapath.sv
rtl/sorted_priority_queue.sv
rtl/spq_checker.sv
bench/sorted_priority_queue_tb.sv
